// ===== hdl/cal_pkg.sv =====
`default_nettype none

package cal_pkg;

	localparam int DATA_W       = 32;
	localparam int FRAC_BITS    = 16;
	localparam int SHIFT_HI     = DATA_W - FRAC_BITS;
	localparam int PROD_W       = 2 * DATA_W;
	localparam int SUM_W        = PROD_W + 1;
	localparam int IN_TDATA_W   = 72;
	localparam int OUT_TDATA_W  = 72;
	localparam int OP_W         = 3;
	localparam int NUM_PRODUCTS = 6;
	localparam int MUL_IDX_W    = 3;
	localparam int MUL_LAST_MUL = 3;
	localparam int MUL_LAST_DIV = NUM_PRODUCTS - 1;
	localparam int DIV_STEPS    = DATA_W;
	localparam int CNT_W        = $clog2(DIV_STEPS);

	typedef enum logic [OP_W-1:0] {
		OP_LOAD = 3'd0,
		OP_ADD  = 3'd1,
		OP_SUB  = 3'd2,
		OP_MUL  = 3'd3,
		OP_DIV  = 3'd4
	} op_t;

	typedef struct packed {
		logic                 load;
		logic                 mul_en;
		logic [MUL_IDX_W-1:0] mul_idx;
		logic                 sum_en;
		logic                 abs_en;
		logic                 div_init;
		logic                 div_step;
		logic                 commit;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic den_zero;
	} status_t;

endpackage

`default_nettype wire

// ===== hdl/cal_ctrl.sv =====
`default_nettype none

module cal_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [2:0]        in_op,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	input  wire cal_pkg::status_t  status,
	output cal_pkg::cmd_t          cmd
);
	import cal_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_MULT  = 7'b0000010,
		ST_SUM   = 7'b0000100,
		ST_ABS   = 7'b0001000,
		ST_DINIT = 7'b0010000,
		ST_DIV   = 7'b0100000,
		ST_FIN   = 7'b1000000
	} state_t;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             out_valid_q, out_valid_d;
	logic             slot_free;
	logic [CNT_W-1:0] mul_last;

	assign s_tready  = (state_q == ST_IDLE);
	assign m_tvalid  = out_valid_q;
	assign slot_free = !out_valid_q || m_tready;
	assign mul_last  = (status.op == OP_DIV) ? CNT_W'(MUL_LAST_DIV) : CNT_W'(MUL_LAST_MUL);

	always_comb begin
		cmd         = '0;
		state_d     = state_q;
		cnt_d       = cnt_q;
		out_valid_d = out_valid_q && !m_tready;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					cnt_d    = '0;
					if (in_op == OP_MUL || in_op == OP_DIV) begin
						state_d = ST_MULT;
					end else begin
						state_d = ST_FIN;
					end
				end
			end
			ST_MULT: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_idx = cnt_q[MUL_IDX_W-1:0];
				if (cnt_q == mul_last) begin
					cnt_d   = '0;
					state_d = ST_SUM;
				end else begin
					cnt_d = cnt_q + CNT_W'(1);
				end
			end
			ST_SUM: begin
				cmd.sum_en = 1'b1;
				state_d    = ST_ABS;
			end
			ST_ABS: begin
				cmd.abs_en = 1'b1;
				if (status.op == OP_DIV && !status.den_zero) begin
					state_d = ST_DINIT;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_DINIT: begin
				cmd.div_init = 1'b1;
				cnt_d        = '0;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					state_d = ST_FIN;
				end else begin
					cnt_d = cnt_q + CNT_W'(1);
				end
			end
			ST_FIN: begin
				if (slot_free) begin
					cmd.commit  = 1'b1;
					out_valid_d = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/cal_dp.sv =====
`default_nettype none

module cal_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire cal_pkg::cmd_t                 cmd,
	input  wire logic [2:0]                    in_op,
	input  wire logic [cal_pkg::DATA_W-1:0]    in_re,
	input  wire logic [cal_pkg::DATA_W-1:0]    in_im,
	output cal_pkg::status_t                   status,
	output logic [cal_pkg::DATA_W-1:0]         res_re,
	output logic [cal_pkg::DATA_W-1:0]         res_im,
	output logic                               res_dz,
	output logic                               res_sat
);
	import cal_pkg::*;

	function automatic logic [DATA_W:0] clamp32(input logic neg, input logic [PROD_W-1:0] mag);
		logic [DATA_W:0] r;
		if (neg) begin
			if (mag > {{(PROD_W-DATA_W){1'b0}}, 1'b1, {(DATA_W-1){1'b0}}}) begin
				r = {1'b1, 1'b1, {(DATA_W-1){1'b0}}};
			end else begin
				r = {1'b0, (~mag[DATA_W-1:0]) + DATA_W'(1)};
			end
		end else begin
			if (mag > {{(PROD_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}}) begin
				r = {1'b1, 1'b0, {(DATA_W-1){1'b1}}};
			end else begin
				r = {1'b0, mag[DATA_W-1:0]};
			end
		end
		return r;
	endfunction

	function automatic logic [DATA_W:0] addsat(input logic [DATA_W-1:0] a,
		input logic [DATA_W-1:0] b, input logic sub);
		logic [DATA_W:0] s;
		logic [DATA_W:0] r;
		if (sub) begin
			s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
		end else begin
			s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
		end
		if (s[DATA_W] != s[DATA_W-1]) begin
			r = {1'b1, s[DATA_W], {(DATA_W-1){~s[DATA_W]}}};
		end else begin
			r = {1'b0, s[DATA_W-1:0]};
		end
		return r;
	endfunction

	function automatic logic [PROD_W:0] dstep(input logic [PROD_W-1:0] rem, input logic nb,
		input logic [PROD_W-1:0] den);
		logic [PROD_W:0] t;
		logic [PROD_W:0] d;
		logic [PROD_W:0] r;
		t = {rem, nb};
		d = {1'b0, den};
		if (t >= d) begin
			d = t - d;
			r = {1'b1, d[PROD_W-1:0]};
		end else begin
			r = {1'b0, t[PROD_W-1:0]};
		end
		return r;
	endfunction

	op_t               op_q;
	logic [DATA_W-1:0] b_re_q, b_im_q;
	logic [DATA_W-1:0] acc_re_q, acc_im_q;
	logic [PROD_W-1:0] prod_q [NUM_PRODUCTS];
	logic [SUM_W-1:0]  sum_re_q, sum_im_q;
	logic [PROD_W-1:0] den_q;
	logic [PROD_W-1:0] mag_re_q, mag_im_q;
	logic              neg_re_q, neg_im_q;
	logic [PROD_W-1:0] rem_re_q, rem_im_q;
	logic [DATA_W-1:0] low_re_q, low_im_q;
	logic [DATA_W-1:0] quo_re_q, quo_im_q;
	logic              ovf_re_q, ovf_im_q;

	logic [DATA_W-1:0] mul_a, mul_b;
	logic [PROD_W-1:0] mul_p;
	logic [SUM_W-1:0]  e0, e1, e2, e3;
	logic [SUM_W-1:0]  abs_re, abs_im;
	logic [PROD_W-1:0] init_re, init_im;
	logic [PROD_W:0]   st_re, st_im;
	logic [PROD_W-1:0] fmag_re, fmag_im;
	logic [DATA_W:0]   c_re, c_im;
	logic [DATA_W:0]   as_re, as_im;
	logic [DATA_W-1:0] fin_re, fin_im;
	logic              fin_dz, fin_sat;

	assign status.op       = op_q;
	assign status.den_zero = (den_q == '0);

	always_comb begin
		unique case (cmd.mul_idx)
			3'd0:    begin mul_a = acc_re_q; mul_b = b_re_q; end
			3'd1:    begin mul_a = acc_im_q; mul_b = b_im_q; end
			3'd2:    begin mul_a = acc_im_q; mul_b = b_re_q; end
			3'd3:    begin mul_a = acc_re_q; mul_b = b_im_q; end
			3'd4:    begin mul_a = b_re_q;   mul_b = b_re_q; end
			default: begin mul_a = b_im_q;   mul_b = b_im_q; end
		endcase
	end

	assign mul_p = $signed(mul_a) * $signed(mul_b);

	assign e0 = {prod_q[0][PROD_W-1], prod_q[0]};
	assign e1 = {prod_q[1][PROD_W-1], prod_q[1]};
	assign e2 = {prod_q[2][PROD_W-1], prod_q[2]};
	assign e3 = {prod_q[3][PROD_W-1], prod_q[3]};

	assign abs_re = sum_re_q[SUM_W-1] ? (~sum_re_q + SUM_W'(1)) : sum_re_q;
	assign abs_im = sum_im_q[SUM_W-1] ? (~sum_im_q + SUM_W'(1)) : sum_im_q;

	assign init_re = mag_re_q >> SHIFT_HI;
	assign init_im = mag_im_q >> SHIFT_HI;

	assign st_re = dstep(rem_re_q, low_re_q[DATA_W-1], den_q);
	assign st_im = dstep(rem_im_q, low_im_q[DATA_W-1], den_q);

	always_comb begin
		if (op_q == OP_DIV) begin
			fmag_re = ovf_re_q ? (PROD_W'(1) << DATA_W) : {{(PROD_W-DATA_W){1'b0}}, quo_re_q};
			fmag_im = ovf_im_q ? (PROD_W'(1) << DATA_W) : {{(PROD_W-DATA_W){1'b0}}, quo_im_q};
		end else begin
			fmag_re = mag_re_q >> FRAC_BITS;
			fmag_im = mag_im_q >> FRAC_BITS;
		end
	end

	assign c_re = clamp32(neg_re_q && (fmag_re != '0), fmag_re);
	assign c_im = clamp32(neg_im_q && (fmag_im != '0), fmag_im);

	assign as_re = addsat(acc_re_q, b_re_q, op_q == OP_SUB);
	assign as_im = addsat(acc_im_q, b_im_q, op_q == OP_SUB);

	always_comb begin
		fin_re  = acc_re_q;
		fin_im  = acc_im_q;
		fin_dz  = 1'b0;
		fin_sat = 1'b0;
		unique case (op_q)
			OP_LOAD: begin
				fin_re = b_re_q;
				fin_im = b_im_q;
			end
			OP_ADD, OP_SUB: begin
				fin_re  = as_re[DATA_W-1:0];
				fin_im  = as_im[DATA_W-1:0];
				fin_sat = as_re[DATA_W] || as_im[DATA_W];
			end
			OP_MUL: begin
				fin_re  = c_re[DATA_W-1:0];
				fin_im  = c_im[DATA_W-1:0];
				fin_sat = c_re[DATA_W] || c_im[DATA_W];
			end
			OP_DIV: begin
				if (den_q == '0) begin
					fin_re = '0;
					fin_im = '0;
					fin_dz = 1'b1;
				end else begin
					fin_re  = c_re[DATA_W-1:0];
					fin_im  = c_im[DATA_W-1:0];
					fin_sat = c_re[DATA_W] || c_im[DATA_W];
				end
			end
			default: begin
				fin_re = acc_re_q;
				fin_im = acc_im_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_re_q <= '0;
			acc_im_q <= '0;
			op_q     <= OP_LOAD;
		end else begin
			if (cmd.load) begin
				op_q <= op_t'(in_op);
			end
			if (cmd.commit) begin
				acc_re_q <= fin_re;
				acc_im_q <= fin_im;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			b_re_q <= in_re;
			b_im_q <= in_im;
		end
		if (cmd.mul_en) begin
			prod_q[cmd.mul_idx] <= mul_p;
		end
		if (cmd.sum_en) begin
			if (op_q == OP_DIV) begin
				sum_re_q <= e0 + e1;
				sum_im_q <= e2 - e3;
			end else begin
				sum_re_q <= e0 - e1;
				sum_im_q <= e2 + e3;
			end
			den_q <= prod_q[4] + prod_q[5];
		end
		if (cmd.abs_en) begin
			neg_re_q <= sum_re_q[SUM_W-1];
			neg_im_q <= sum_im_q[SUM_W-1];
			mag_re_q <= abs_re[PROD_W-1:0];
			mag_im_q <= abs_im[PROD_W-1:0];
		end
		if (cmd.div_init) begin
			rem_re_q <= init_re;
			rem_im_q <= init_im;
			ovf_re_q <= (init_re >= den_q);
			ovf_im_q <= (init_im >= den_q);
			low_re_q <= {mag_re_q[SHIFT_HI-1:0], {FRAC_BITS{1'b0}}};
			low_im_q <= {mag_im_q[SHIFT_HI-1:0], {FRAC_BITS{1'b0}}};
			quo_re_q <= '0;
			quo_im_q <= '0;
		end
		if (cmd.div_step) begin
			rem_re_q <= st_re[PROD_W-1:0];
			rem_im_q <= st_im[PROD_W-1:0];
			quo_re_q <= {quo_re_q[DATA_W-2:0], st_re[PROD_W]};
			quo_im_q <= {quo_im_q[DATA_W-2:0], st_im[PROD_W]};
			low_re_q <= {low_re_q[DATA_W-2:0], 1'b0};
			low_im_q <= {low_im_q[DATA_W-2:0], 1'b0};
		end
		if (cmd.commit) begin
			res_re  <= fin_re;
			res_im  <= fin_im;
			res_dz  <= fin_dz;
			res_sat <= fin_sat;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/complex_accumulator_alu_top.sv =====
// Channel  | Direction | Handshake         | Payload
// s_*      | in        | s_tvalid/s_tready | s_tdata: op, operand_real, operand_imag
// m_*      | out       | m_tvalid/m_tready | m_tdata: acc_real, acc_imag, div_by_zero, saturated
//
// Load, add, subtract and undefined codes go straight to the commit step; multiply makes
// four passes through the single 32x32 multiplier; divide makes six multiplier passes and
// then runs the 32-step restoring divider that forms both quotient parts.
// A divide by 0+0j skips the divider.
// arst_n clears the accumulator to 0+0j and empties the output register.
// A stalled m_tready holds the finished result; the next transaction is taken and worked
// on meanwhile and waits at its commit step until the output register frees.
`default_nettype none

module complex_accumulator_alu_top (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// [2:0] op, [34:3] operand_real, [66:35] operand_imag, [71:67] zero
	input  wire logic [cal_pkg::IN_TDATA_W-1:0]    s_tdata,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// [31:0] acc_real, [63:32] acc_imag, [64] div_by_zero, [65] saturated, [71:66] zero
	output logic [cal_pkg::OUT_TDATA_W-1:0]        m_tdata
);
	import cal_pkg::*;

	cmd_t              cmd;
	status_t           status;
	logic [2:0]        in_op;
	logic [DATA_W-1:0] in_re, in_im;
	logic [DATA_W-1:0] res_re, res_im;
	logic              res_dz, res_sat;

	assign in_op = s_tdata[OP_W-1:0];
	assign in_re = s_tdata[OP_W +: DATA_W];
	assign in_im = s_tdata[OP_W+DATA_W +: DATA_W];

	assign m_tdata = {{(OUT_TDATA_W-2*DATA_W-2){1'b0}}, res_sat, res_dz, res_im, res_re};

	cal_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.in_op    (in_op),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	cal_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.in_op   (in_op),
		.in_re   (in_re),
		.in_im   (in_im),
		.status  (status),
		.res_re  (res_re),
		.res_im  (res_im),
		.res_dz  (res_dz),
		.res_sat (res_sat)
	);

endmodule

`default_nettype wire
